[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the queue checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dpq assertion failed");

// Next-cycle implication, disabled while reset is high.
`define DPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dpq assertion failed");

`endif

[sv/dpq_pkg.sv]
// ----------------------------------------------------------------------------
// dpq_pkg
// Constants, codes and types of the dual-policy waiting queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dpq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 32;
  localparam int VAL_W    = 32;

  typedef logic [1:0] mode_t;
  typedef logic [1:0] status_t;

  localparam mode_t MODE_ARRIVE  = 2'd0;
  localparam mode_t MODE_OLDEST  = 2'd1;
  localparam mode_t MODE_HIGHEST = 2'd2;
  localparam mode_t MODE_NONE    = 2'd3;

  localparam status_t ST_SERVED = 2'd0;
  localparam status_t ST_EMPTY  = 2'd1;
  localparam status_t ST_FULL   = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

`default_nettype wire

[sv/dpq_if.sv]
// ----------------------------------------------------------------------------
// dpq_req_if / dpq_rsp_if
// Valid/ready channels for requests into and results out of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpq_req_if;
  logic              valid;
  logic              ready;
  dpq_pkg::mode_t    mode;
  logic [31:0]       value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface dpq_rsp_if;
  logic              valid;
  logic              ready;
  dpq_pkg::status_t  status;
  logic [31:0]       served_id;
  logic [31:0]       served_value;

  modport source (output valid, output status, output served_id, output served_value,
                  input ready);
  modport sink   (input valid, input status, input served_id, input served_value,
                  output ready);
endinterface

`default_nettype wire

[sv/dpq_cmp.sv]
// ----------------------------------------------------------------------------
// dpq_cmp
// Shared compare unit: decide whether a scanned entry beats the current pick.
// ----------------------------------------------------------------------------
`default_nettype none

module dpq_cmp (
  input  dpq_pkg::mode_t  mode,
  input  logic            have_best,
  input  dpq_pkg::entry_t cand,
  input  dpq_pkg::entry_t best,
  output logic            take
);
  import dpq_pkg::*;

  logic id_less;
  logic val_more;
  logic val_same;

  assign id_less  = cand.id < best.id;
  assign val_more = cand.value > best.value;
  assign val_same = cand.value == best.value;

  always_comb begin
    if (!have_best) begin
      take = 1'b1;
    end else if (mode == MODE_OLDEST) begin
      take = id_less;
    end else begin
      // highest value wins, oldest breaks a tie
      take = val_more || (val_same && id_less);
    end
  end

endmodule

`default_nettype wire

[sv/dual_policy_fifo_priority_queue.sv]
// Arrival: walk to the lowest free slot; no result.
// Serve: scan every slot into the result register; empty/full/drop skip the walk and the scan.
// Throughput: one item at a time; the memory read port and the compare unit
//   visit every slot once per serve.
// Reset (rst, synchronous): clears slot-valid bits, occupancy, state and output
//   valid; next sequence number returns to one. Entry memory is not cleared.
// ----------------------------------------------------------------------------
// dual_policy_fifo_priority_queue
// Waiting queue served either oldest-first or highest-value-first.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_policy_fifo_priority_queue (
  input  wire logic  clk,
  input  wire logic  rst,
  dpq_req_if.sink    req,
  dpq_rsp_if.source  rsp
);
  import dpq_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // take a request
  localparam logic [2:0] S_FIND = 3'd1;  // walk valid bits for a free slot
  localparam logic [2:0] S_SCAN = 3'd2;  // read every slot, keep the best
  localparam logic [2:0] S_EMIT = 3'd3;  // hand result to output register

  logic [2:0]        state;

  // Slot bookkeeping: valid bits in flops, payload in memory
  logic [CAPACITY-1:0] valid;
  logic [CNT_W-1:0]    occupancy;
  logic [ID_W-1:0]     next_id;

  entry_t            mem [CAPACITY];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  entry_t            mem_wd;
  logic [IDX_W-1:0]  mem_ra;
  entry_t            rd_entry;

  // Request held for the duration of the work
  mode_t             cur_mode;
  logic [VAL_W-1:0]  cur_value;

  // Scan pointers and pick
  logic [IDX_W-1:0]  fidx;
  logic [CNT_W-1:0]  cnt;
  logic              cand_live;
  logic              cand_vld;
  logic [IDX_W-1:0]  cand_idx;
  logic              have_best;
  logic [IDX_W-1:0]  best_idx;
  entry_t            best;
  logic              take;

  // Result waiting to be loaded into the output register
  status_t           res_status;

  // Output register
  logic              out_valid;
  status_t           out_status;
  logic [ID_W-1:0]   out_id;
  logic [VAL_W-1:0]  out_value;

  logic              req_fire;
  logic              out_free;
  logic              scan_done;
  logic              is_full;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign scan_done = (cnt == CNT_W'(CAPACITY));
  assign is_full   = (occupancy == CNT_W'(CAPACITY)) || (next_id == '0);

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.served_id    = out_id;
  assign rsp.served_value = out_value;

  // Memory ports: write a new arrival, read the slot under the scan counter
  assign mem_we    = (state == S_FIND) && !valid[fidx];
  assign mem_wa    = fidx;
  assign mem_wd.id    = next_id;
  assign mem_wd.value = cur_value;
  assign mem_ra    = cnt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_entry <= mem[mem_ra];
  end

  // Shared compare unit: the entry read last cycle against the current pick
  dpq_cmp u_cmp (
    .mode      (cur_mode),
    .have_best (have_best),
    .cand      (rd_entry),
    .best      (best),
    .take      (take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      occupancy <= '0;
      next_id   <= ID_W'(1);
      out_valid <= 1'b0;
      cand_live <= 1'b0;
      have_best <= 1'b0;
    end else begin
      // Load the output register from S_EMIT; drop it once it has been transferred
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_fire) begin
            cur_mode  <= req.mode;
            cur_value <= req.value;
            fidx      <= '0;
            cnt       <= '0;
            cand_live <= 1'b0;
            have_best <= 1'b0;
            if (req.mode == MODE_ARRIVE) begin
              if (is_full) begin
                res_status <= ST_FULL;
                state      <= S_EMIT;
              end else begin
                state <= S_FIND;
              end
            end else if (req.mode == MODE_NONE) begin
              state <= S_IDLE;
            end else if (occupancy == '0) begin
              res_status <= ST_EMPTY;
              state      <= S_EMIT;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_FIND: begin
          // A free slot exists, since occupancy is below capacity
          if (!valid[fidx]) begin
            valid[fidx] <= 1'b1;
            next_id     <= next_id + ID_W'(1);
            occupancy   <= occupancy + CNT_W'(1);
            state       <= S_IDLE;
          end else begin
            fidx <= fidx + IDX_W'(1);
          end
        end

        S_SCAN: begin
          // Issue one read per cycle; compare the slot read the cycle before
          if (!scan_done) begin
            cand_live <= 1'b1;
            cand_vld  <= valid[cnt[IDX_W-1:0]];
            cand_idx  <= cnt[IDX_W-1:0];
            cnt       <= cnt + CNT_W'(1);
          end else begin
            cand_live  <= 1'b0;
            res_status <= ST_SERVED;
            state      <= S_EMIT;
          end
          if (cand_live && cand_vld && take) begin
            have_best <= 1'b1;
            best      <= rd_entry;
            best_idx  <= cand_idx;
          end
        end

        S_EMIT: begin
          // Hold until the output register is free, then load the result
          if (out_free) begin
            out_status <= res_status;
            if (res_status == ST_SERVED) begin
              out_id           <= best.id;
              out_value        <= best.value;
              valid[best_idx]  <= 1'b0;
              occupancy        <= occupancy - CNT_W'(1);
            end else begin
              out_id    <= '0;
              out_value <= '0;
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/dpq_checker.sv]
// ----------------------------------------------------------------------------
// dpq_checker
// Port-level checks of the dual-policy queue, bound onto the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dpq_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_valid,
  input wire logic              req_ready,
  input wire dpq_pkg::mode_t    req_mode,
  input wire logic              rsp_valid,
  input wire logic              rsp_ready,
  input wire dpq_pkg::status_t  rsp_status,
  input wire logic [31:0]       rsp_served_id,
  input wire logic [31:0]       rsp_served_value
);
  import dpq_pkg::*;

  logic        rsp_stall;
  logic        rsp_served;
  logic        rsp_unserved;
  logic        rsp_zero;
  logic        req_work;
  logic [65:0] rsp_payload;

  assign rsp_stall    = rsp_valid && !rsp_ready;
  assign rsp_served   = rsp_valid && (rsp_status == ST_SERVED);
  assign rsp_unserved = rsp_valid && (rsp_status != ST_SERVED);
  assign rsp_zero     = (rsp_served_id == 32'd0) && (rsp_served_value == 32'd0);
  assign rsp_payload  = {rsp_status, rsp_served_id, rsp_served_value};
  // Ignored requests leave the block ready
  assign req_work     = req_valid && req_ready && (req_mode != MODE_NONE);

  // A stalled result holds its payload
  `DPQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_stall, rsp_valid && $stable(rsp_payload))

  // Nothing served: number and value read as zero
  `DPQ_ASSERT_NOW(a_unserved_zero, clk, rst, rsp_unserved, rsp_zero)

  // A served entry always carries a sequence number from one upward
  `DPQ_ASSERT_NOW(a_served_id, clk, rst, rsp_served, rsp_served_id != 32'd0)

  // One request at a time: busy right after a working transfer
  `DPQ_ASSERT_NEXT(a_busy_after_req, clk, rst, req_work, !req_ready)

endmodule

bind dual_policy_fifo_priority_queue dpq_checker u_dpq_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .req_mode         (req.mode),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_served_id    (rsp.served_id),
  .rsp_served_value (rsp.served_value)
);

`default_nettype wire

[tb/dual_policy_fifo_priority_queue_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_policy_fifo_priority_queue_test
// Self-checking bench for the dual-policy waiting queue. A scripted opening
// covers empty serves, ignored requests, extreme values and equal-value ties.
// Random traffic follows: arrival/serve runs, tie storms, fill-to-full and
// drain passes, and noise. Each transfer is predicted by an in-bench model of
// the slot store. Results are checked in order under varying idle and stall
// pressure.
// ----------------------------------------------------------------------------

module dual_policy_fifo_priority_queue_test;
  import dpq_pkg::*;

  localparam int CLK_HALF   = 5;
  localparam int RST_CYCLES = 8;
  localparam int LIMIT      = 1000000;
  localparam int HOLD_LEN   = 500;
  localparam int PHASE_ITEMS = 385;

  typedef struct packed {
    status_t     status;
    logic [31:0] id;
    logic [31:0] value;
  } served_t;

  // One row of the scripted opening; typed rows carry a hand-read result.
  typedef struct packed {
    mode_t       mode;
    logic [31:0] value;
    logic        typed;
    status_t     st;
    logic [31:0] id;
    logic [31:0] val;
  } script_row_t;

  localparam int SCRIPT_LEN = 21;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{MODE_OLDEST,  32'h0000_0000, 1'b1, ST_EMPTY,  32'd0, 32'd0},
    '{MODE_HIGHEST, 32'hFFFF_FFFF, 1'b1, ST_EMPTY,  32'd0, 32'd0},
    '{MODE_NONE,    32'hFFFF_FFFF, 1'b0, ST_SERVED, 32'd0, 32'd0},
    '{MODE_ARRIVE,  32'hFFFF_FFFF, 1'b0, ST_SERVED, 32'd0, 32'd0},
    '{MODE_ARRIVE,  32'h0000_0000, 1'b0, ST_SERVED, 32'd0, 32'd0},
    '{MODE_ARRIVE,  32'hFFFF_FFFF, 1'b0, ST_SERVED, 32'd0, 32'd0},
    '{MODE_ARRIVE,  32'h0000_0007, 1'b0, ST_SERVED, 32'd0, 32'd0},
    '{MODE_HIGHEST, 32'h1234_5678, 1'b1, ST_SERVED, 32'd1, 32'hFFFF_FFFF},
    '{MODE_HIGHEST, 32'h0000_0000, 1'b1, ST_SERVED, 32'd3, 32'hFFFF_FFFF},
    '{MODE_ARRIVE,  32'h0000_0007, 1'b0, ST_SERVED, 32'd0, 32'd0},
    '{MODE_HIGHEST, 32'hFFFF_FFFF, 1'b0, ST_SERVED, 32'd0, 32'd0},
    '{MODE_OLDEST,  32'h0000_0000, 1'b1, ST_SERVED, 32'd2, 32'd0},
    '{MODE_NONE,    32'h0000_0000, 1'b0, ST_SERVED, 32'd0, 32'd0},
    '{MODE_ARRIVE,  32'h8000_0000, 1'b0, ST_SERVED, 32'd0, 32'd0},
    '{MODE_OLDEST,  32'h5555_5555, 1'b0, ST_SERVED, 32'd0, 32'd0},
    '{MODE_OLDEST,  32'hAAAA_AAAA, 1'b0, ST_SERVED, 32'd0, 32'd0},
    '{MODE_OLDEST,  32'h0000_0000, 1'b1, ST_EMPTY,  32'd0, 32'd0},
    '{MODE_HIGHEST, 32'h0000_0000, 1'b1, ST_EMPTY,  32'd0, 32'd0},
    '{MODE_ARRIVE,  32'h0000_0000, 1'b0, ST_SERVED, 32'd0, 32'd0},
    '{MODE_HIGHEST, 32'h0000_0000, 1'b0, ST_SERVED, 32'd0, 32'd0},
    '{MODE_OLDEST,  32'hFFFF_FFFF, 1'b1, ST_EMPTY,  32'd0, 32'd0}
  };

  logic clk;
  logic rst;

  dpq_req_if req_ch ();
  dpq_rsp_if rsp_ch ();

  dual_policy_fifo_priority_queue dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the slot store.
  logic        slot_used [CAPACITY];
  logic [31:0] slot_seq  [CAPACITY];
  logic [31:0] slot_val  [CAPACITY];
  logic [31:0] seq_next;
  int          fill_count;

  served_t pending_results [$];

  int  errors;
  int  items_sent;
  int  cycles;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_req;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Apply one accepted request to the shadow store; return 1 when it yields
  // a result, with the result in r.
  function automatic bit predict_service(input mode_t m, input logic [31:0] v,
                                         output served_t r);
    int pick;
    bit produced;
    pick = -1;
    produced = 1'b0;
    r = '{ST_SERVED, 32'd0, 32'd0};
    if (m == MODE_ARRIVE) begin
      // Drop when the store is full or the sequence numbers are spent.
      if (fill_count >= CAPACITY || seq_next == 32'd0) begin
        r.status = ST_FULL;
        produced = 1'b1;
      end else begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (!slot_used[i] && pick < 0) pick = i;
        end
        slot_used[pick] = 1'b1;
        slot_seq[pick]  = seq_next;
        slot_val[pick]  = v;
        seq_next        = seq_next + 32'd1;
        fill_count++;
      end
    end else if (m != MODE_NONE) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (slot_used[i]) begin
          if (pick < 0) begin
            pick = i;
          end else if (m == MODE_OLDEST) begin
            if (slot_seq[i] < slot_seq[pick]) pick = i;
          end else if (slot_val[i] > slot_val[pick] ||
                       (slot_val[i] == slot_val[pick] && slot_seq[i] < slot_seq[pick])) begin
            pick = i;
          end
        end
      end
      produced = 1'b1;
      if (pick < 0) begin
        r.status = ST_EMPTY;
      end else begin
        slot_used[pick] = 1'b0;
        fill_count--;
        r = '{ST_SERVED, slot_seq[pick], slot_val[pick]};
      end
    end
    return produced;
  endfunction

  // Skew toward small values and extremes so ties and edge bits come often.
  function automatic logic [31:0] pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return $urandom;
    if (roll < 75) return $urandom_range(3);
    if (roll < 88) return 32'hFFFF_FFFF;
    if (roll < 94) return 32'd0;
    return 32'd1 << $urandom_range(31);
  endfunction

  function automatic mode_t serve_mode();
    return ($urandom_range(1) == 0) ? MODE_OLDEST : MODE_HIGHEST;
  endfunction

  // Offer one request and hold it until the transfer; idle first at random.
  task automatic transfer(input mode_t m, input logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode  <= m;
    req_ch.value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic issue(input mode_t m, input logic [31:0] v);
    served_t r;
    transfer(m, v);
    if (predict_service(m, v, r)) pending_results.push_back(r);
    items_sent++;
  endtask

  // Drop valid and hold until every predicted result has been checked.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic random_mix(input int quota);
    int stop_at;
    int roll;
    int n;
    bit filled;
    stop_at = items_sent + quota;
    filled = 1'b0;
    while (items_sent < stop_at) begin
      roll = $urandom_range(99);
      if (!filled && (roll < 4 || items_sent >= stop_at - quota / 2)) begin
        // Fill the store, push past full, then drain it and serve once more.
        filled = 1'b1;
        while (fill_count < CAPACITY) issue(MODE_ARRIVE, pick_value());
        n = $urandom_range(1, 3);
        repeat (n) issue(MODE_ARRIVE, pick_value());
        while (fill_count > 0) issue(serve_mode(), $urandom);
        issue(serve_mode(), $urandom);
      end else if (roll < 70) begin
        n = $urandom_range(1, 8);
        repeat (n) if (fill_count < CAPACITY) issue(MODE_ARRIVE, pick_value());
        n = $urandom_range(1, fill_count + 1);
        repeat (n) issue(serve_mode(), $urandom);
      end else if (roll < 85) begin
        // Equal values: the oldest among them must win a highest-value serve.
        n = $urandom_range(2, 6);
        repeat (n) if (fill_count < CAPACITY) issue(MODE_ARRIVE, $urandom_range(3));
        n = $urandom_range(1, fill_count);
        repeat (n) issue(MODE_HIGHEST, $urandom);
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) issue(mode_t'($urandom_range(3)), $urandom);
      end
    end
  endtask

  // Receiver: stall at random; on request hold off for a long stretch.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    served_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0h id %0h value %0h",
               rsp_ch.status, rsp_ch.served_id, rsp_ch.served_value);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0h, got %0h", want.status, rsp_ch.status);
          errors++;
        end
        if (rsp_ch.served_id !== want.id) begin
          $error("served_id: expected %0h, got %0h", want.id, rsp_ch.served_id);
          errors++;
        end
        if (rsp_ch.served_value !== want.value) begin
          $error("served_value: expected %0h, got %0h", want.value, rsp_ch.served_value);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("dual_policy_fifo_priority_queue_test: errors");
      $finish;
    end
  end

  initial begin
    served_t r;
    errors = 0;
    items_sent = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    for (int i = 0; i < CAPACITY; i++) slot_used[i] = 1'b0;
    seq_next = 32'd1;
    fill_count = 0;

    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.mode  <= MODE_ARRIVE;
    req_ch.value <= 32'd0;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Scripted opening: typed rows replace the prediction, the model still
    // advances on every row.
    for (int k = 0; k < SCRIPT_LEN; k++) begin
      transfer(SCRIPT[k].mode, SCRIPT[k].value);
      if (predict_service(SCRIPT[k].mode, SCRIPT[k].value, r)) begin
        if (SCRIPT[k].typed) pending_results.push_back('{SCRIPT[k].st, SCRIPT[k].id,
                                                         SCRIPT[k].val});
        else pending_results.push_back(r);
      end
      items_sent++;
    end
    wait_drained();

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      random_mix(PHASE_ITEMS);
      wait_drained();
    end

    // Back-pressure: receiver holds off while serves keep coming, so the
    // result path backs up and the request side stalls.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    repeat (4) issue(MODE_ARRIVE, pick_value());
    repeat (6) issue(serve_mode(), $urandom);
    wait_drained();

    // Let any request still in flight finish; nothing more may come out.
    repeat (CAPACITY + 8) @(posedge clk);
    if (errors == 0) begin
      $display("dual_policy_fifo_priority_queue_test: clean");
    end else begin
      $display("dual_policy_fifo_priority_queue_test: errors");
    end
    $finish;
  end

endmodule
